@@ rtl/max_pool_2d_stream_defines.svh @@
// Assertion macros shared by the max pooling block.
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

`ifndef SYNTHESIS

`define MP2D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define MP2D_NEVER(label, cond, msg) \
    `MP2D_ASSERT(label, !(cond), msg)

`else

`define MP2D_ASSERT(label, prop, msg)

`define MP2D_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/mp2d_pkg.sv @@
// Shared constants and types of the max pooling block.
package mp2d_pkg;

    localparam int DIM_W      = 11;
    localparam int POOL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int OUT_IDX_W  = 10;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_MAX_POOL    = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0]  RESET_MAP_WIDTH  = DIM_W'(32);
    localparam logic [DIM_W-1:0]  RESET_MAP_HEIGHT = DIM_W'(32);
    localparam logic [POOL_W-1:0] RESET_POOL_SIZE  = POOL_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_POOL_SIZE  = 2'd2
    } cfg_index_t;

    // Classification of one sample, made at the input side.
    typedef struct packed {
        logic first;  // opens a window
        logic emit;   // closes a window
        logic done;   // closes the last window of the map
        logic err;    // configuration unusable
    } mp2d_flags_t;

    typedef struct packed {
        logic busy;     // dimension check in progress
        logic usable;   // configuration passes all checks
        logic restart;  // register written this cycle
    } mp2d_cfg_stat_t;

endpackage

@@ rtl/max_pool_2d_stream.sv @@
// Top level of the streaming 2D max pooling block.
// Takes one signed sample per cycle in raster order unless m_ready or a check stalls it,
// and returns one result per completed pooling window (bottom-right sample), or one
// error result per sample while the map size is not a multiple of the pool size or a
// size is out of range. The column maximum RAM is read as a sample enters the execute
// stage and written as it leaves, with the last write forwarded to the next read. Samples
// pass the queue, RAM read and result register. A write to any configuration register
// starts a bit-serial divisibility check of width and height that holds s_ready low.
module max_pool_2d_stream #(
    parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_POOL    = mp2d_pkg::DEF_MAX_POOL,
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_pooled_value,
    output logic [mp2d_pkg::OUT_IDX_W-1:0]   m_out_row,
    output logic [mp2d_pkg::OUT_IDX_W-1:0]   m_out_col,
    output logic                             m_map_done,
    output logic                             m_size_error,
    input  logic                             cfg_wr_en,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import mp2d_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = $bits(mp2d_flags_t);
    localparam int QW = SAMPLE_BITS + CW + RW + FW;

    logic [DIM_W-1:0]       map_width;
    logic [DIM_W-1:0]       map_height;
    logic [POOL_W-1:0]      pool_size;
    mp2d_cfg_stat_t         cfg_stat;

    logic                   q_full;
    logic                   q_push;
    logic [SAMPLE_BITS-1:0] push_pixel;
    logic [CW-1:0]          push_col;
    logic [RW-1:0]          push_row;
    mp2d_flags_t            push_flags;

    logic                   q_pop;
    logic                   q_valid;
    logic [QW-1:0]          q_head;
    logic [SAMPLE_BITS-1:0] head_pixel;
    logic [CW-1:0]          head_col;
    logic [RW-1:0]          head_row;
    mp2d_flags_t            head_flags;

    mp2d_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_POOL   (MAX_POOL)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .map_width  (map_width),
        .map_height (map_height),
        .pool_size  (pool_size),
        .stat       (cfg_stat)
    );

    mp2d_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_POOL    (MAX_POOL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .map_width  (map_width),
        .map_height (map_height),
        .pool_size  (pool_size),
        .stat       (cfg_stat),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_pixel    (push_pixel),
        .q_col      (push_col),
        .q_row      (push_row),
        .q_flags    (push_flags)
    );

    mp2d_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({push_pixel, push_col, push_row, push_flags}),
        .full       (q_full),
        .pop        (q_pop),
        .head_data  (q_head),
        .head_valid (q_valid)
    );

    assign {head_pixel, head_col, head_row, head_flags} = q_head;

    mp2d_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_pixel        (head_pixel),
        .q_col          (head_col),
        .q_row          (head_row),
        .q_flags        (head_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_map_done     (m_map_done),
        .m_size_error   (m_size_error)
    );

endmodule

@@ rtl/mp2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // A read in the same cycle as a write to that address returns the old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ rtl/mp2d_cfg.sv @@
// Configuration registers and the serial divisibility check.
module mp2d_cfg #(
    parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_POOL   = mp2d_pkg::DEF_MAX_POOL
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [mp2d_pkg::DIM_W-1:0]       map_width,
    output logic [mp2d_pkg::DIM_W-1:0]       map_height,
    output logic [mp2d_pkg::POOL_W-1:0]      pool_size,
    output mp2d_pkg::mp2d_cfg_stat_t         stat
);

    import mp2d_pkg::*;

    localparam int BIT_W = $clog2(DIM_W);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [POOL_W-1:0] pool_reg;
    logic              busy_reg;
    logic              usable_reg;
    logic [BIT_W-1:0]  bit_idx_reg;
    logic [POOL_W-1:0] rem_w_reg;
    logic [POOL_W-1:0] rem_h_reg;

    logic              wr_hit;
    logic [POOL_W-1:0] rem_w_next;
    logic [POOL_W-1:0] rem_h_next;
    logic              range_ok;

    // One bit of a remainder: r = (2r + b) mod p, with r < p on entry.
    function automatic logic [POOL_W-1:0] mod_step(input logic [POOL_W-1:0] r,
                                                   input logic              b,
                                                   input logic [POOL_W-1:0] p);
        logic [POOL_W:0] t;
        t = {r, b};
        if (t >= {1'b0, p}) begin
            t = t - {1'b0, p};
        end
        return t[POOL_W-1:0];
    endfunction

    assign wr_hit = cfg_wr_en && (cfg_index == REG_MAP_WIDTH ||
                                  cfg_index == REG_MAP_HEIGHT ||
                                  cfg_index == REG_POOL_SIZE);

    assign rem_w_next = mod_step(rem_w_reg, width_reg[bit_idx_reg], pool_reg);
    assign rem_h_next = mod_step(rem_h_reg, height_reg[bit_idx_reg], pool_reg);

    assign range_ok = (pool_reg != '0) && (int'(pool_reg) <= MAX_POOL) &&
                      (width_reg != '0) && (int'(width_reg) <= MAX_WIDTH) &&
                      (height_reg != '0) && (int'(height_reg) <= MAX_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RESET_MAP_WIDTH;
            height_reg  <= RESET_MAP_HEIGHT;
            pool_reg    <= RESET_POOL_SIZE;
            busy_reg    <= 1'b0;
            usable_reg  <= 1'b1;
            bit_idx_reg <= '0;
            rem_w_reg   <= '0;
            rem_h_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAP_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                    REG_MAP_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                    REG_POOL_SIZE:  pool_reg   <= cfg_wdata[POOL_W-1:0];
                    default: ;
                endcase
            end
            // Restart the check from the top bit on every write to a configuration register.
            if (wr_hit) begin
                busy_reg    <= 1'b1;
                bit_idx_reg <= BIT_W'(DIM_W - 1);
                rem_w_reg   <= '0;
                rem_h_reg   <= '0;
            end else if (busy_reg) begin
                rem_w_reg   <= rem_w_next;
                rem_h_reg   <= rem_h_next;
                bit_idx_reg <= bit_idx_reg - 1'b1;
                if (bit_idx_reg == '0) begin
                    busy_reg   <= 1'b0;
                    usable_reg <= range_ok && (rem_w_next == '0) && (rem_h_next == '0);
                end
            end
        end
    end

    assign map_width    = width_reg;
    assign map_height   = height_reg;
    assign pool_size    = pool_reg;
    assign stat.busy    = busy_reg;
    assign stat.usable  = usable_reg;
    assign stat.restart = wr_hit;

endmodule

@@ rtl/mp2d_front.sv @@
// Input side: raster position tracking and window classification.
module mp2d_front #(
    parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_POOL    = mp2d_pkg::DEF_MAX_POOL,
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0]                 s_pixel,
    input  logic [mp2d_pkg::DIM_W-1:0]                    map_width,
    input  logic [mp2d_pkg::DIM_W-1:0]                    map_height,
    input  logic [mp2d_pkg::POOL_W-1:0]                   pool_size,
    input  mp2d_pkg::mp2d_cfg_stat_t                      stat,
    input  logic                                          q_full,
    output logic                                          q_push,
    output logic [SAMPLE_BITS-1:0]                        q_pixel,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]   q_col,
    output logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row,
    output mp2d_pkg::mp2d_flags_t                         q_flags
);

    import mp2d_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

    logic [CW-1:0] col_reg;
    logic [PW-1:0] ciw_reg;
    logic [CW-1:0] ocol_reg;
    logic [RW-1:0] row_reg;
    logic [PW-1:0] riw_reg;
    logic [RW-1:0] orow_reg;

    logic accept;
    logic advance;
    logic ciw_last;
    logic riw_last;
    logic col_last;
    logic row_last;

    assign s_ready = !q_full && !stat.busy;
    assign accept  = s_valid && s_ready;
    assign advance = accept && stat.usable;

    assign ciw_last = int'(ciw_reg) == int'(pool_size) - 1;
    assign riw_last = int'(riw_reg) == int'(pool_size) - 1;
    assign col_last = int'(col_reg) == int'(map_width) - 1;
    assign row_last = int'(row_reg) == int'(map_height) - 1;

    always_ff @(posedge aclk) begin
        if (!aresetn || stat.restart) begin
            col_reg  <= '0;
            ciw_reg  <= '0;
            ocol_reg <= '0;
            row_reg  <= '0;
            riw_reg  <= '0;
            orow_reg <= '0;
        end else if (advance) begin
            if (col_last) begin
                col_reg  <= '0;
                ciw_reg  <= '0;
                ocol_reg <= '0;
                if (row_last) begin
                    row_reg  <= '0;
                    riw_reg  <= '0;
                    orow_reg <= '0;
                end else begin
                    row_reg  <= row_reg + 1'b1;
                    riw_reg  <= riw_last ? '0 : riw_reg + 1'b1;
                    orow_reg <= riw_last ? orow_reg + 1'b1 : orow_reg;
                end
            end else begin
                col_reg  <= col_reg + 1'b1;
                ciw_reg  <= ciw_last ? '0 : ciw_reg + 1'b1;
                ocol_reg <= ciw_last ? ocol_reg + 1'b1 : ocol_reg;
            end
        end
    end

    assign q_push        = accept;
    assign q_pixel       = s_pixel;
    assign q_col         = ocol_reg;
    assign q_row         = orow_reg;
    assign q_flags.first = (riw_reg == '0) && (ciw_reg == '0);
    assign q_flags.emit  = riw_last && ciw_last;
    assign q_flags.done  = riw_last && ciw_last && row_last && col_last;
    assign q_flags.err   = !stat.usable;

endmodule

@@ rtl/mp2d_queue.sv @@
// Short FIFO between the classifying front and the pooling back end.
module mp2d_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = mp2d_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid
);

    `include "max_pool_2d_stream_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];

    `MP2D_NEVER(a_push_when_full, push && full, "queue overflow")
    `MP2D_NEVER(a_pop_when_empty, pop && !head_valid, "queue underflow")
    `MP2D_ASSERT(a_count_bound, int'(count_reg) <= DEPTH, "queue count past depth")

endmodule

@@ rtl/mp2d_back.sv @@
// Back end: column maximum read-modify-write and the result register.
module mp2d_back #(
    parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          q_valid,
    output logic                                          q_pop,
    input  logic [SAMPLE_BITS-1:0]                        q_pixel,
    input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0]   q_col,
    input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] q_row,
    input  mp2d_pkg::mp2d_flags_t                         q_flags,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]                 m_pooled_value,
    output logic [mp2d_pkg::OUT_IDX_W-1:0]                m_out_row,
    output logic [mp2d_pkg::OUT_IDX_W-1:0]                m_out_col,
    output logic                                          m_map_done,
    output logic                                          m_size_error
);

    import mp2d_pkg::*;
    `include "max_pool_2d_stream_defines.svh"

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Execute stage, aligned with the RAM read data.
    logic                   b_valid_reg;
    logic [SAMPLE_BITS-1:0] b_pixel_reg;
    logic [CW-1:0]          b_col_reg;
    logic [RW-1:0]          b_row_reg;
    mp2d_flags_t            b_flags_reg;

    // Last write to the column buffer, for a read that missed it.
    logic                   fwd_valid_reg;
    logic [CW-1:0]          fwd_addr_reg;
    logic [SAMPLE_BITS-1:0] fwd_data_reg;

    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;
    logic [OUT_IDX_W-1:0]   m_row_reg;
    logic [OUT_IDX_W-1:0]   m_col_reg;
    logic                   m_done_reg;
    logic                   m_err_reg;

    logic                   out_free;
    logic                   b_emit;
    logic                   advance;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] prev_max;
    logic [SAMPLE_BITS-1:0] new_max;
    logic                   ram_we;

    assign out_free = !m_valid_reg || m_ready;
    assign b_emit   = b_flags_reg.emit || b_flags_reg.err;
    assign advance  = !b_valid_reg || !b_emit || out_free;
    assign q_pop    = advance && q_valid;

    assign prev_max = (fwd_valid_reg && fwd_addr_reg == b_col_reg) ? fwd_data_reg : rd_data;
    assign new_max  = (b_flags_reg.first || $signed(b_pixel_reg) > $signed(prev_max)) ?
                      b_pixel_reg : prev_max;
    assign ram_we   = b_valid_reg && advance && !b_flags_reg.err;

    mp2d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_col_max (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (b_col_reg),
        .wr_data (new_max),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_pixel_reg <= q_pixel;
            b_col_reg   <= q_col;
            b_row_reg   <= q_row;
            b_flags_reg <= q_flags;
        end
        if (ram_we) begin
            fwd_addr_reg <= b_col_reg;
            fwd_data_reg <= new_max;
        end
        if (b_valid_reg && advance && b_emit) begin
            m_value_reg <= b_flags_reg.err ? '0 : new_max;
            m_row_reg   <= b_flags_reg.err ? '0 : OUT_IDX_W'(b_row_reg);
            m_col_reg   <= b_flags_reg.err ? '0 : OUT_IDX_W'(b_col_reg);
            m_done_reg  <= b_flags_reg.done && !b_flags_reg.err;
            m_err_reg   <= b_flags_reg.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                b_valid_reg <= q_valid;
            end
            if (ram_we) begin
                fwd_valid_reg <= 1'b1;
            end
            if (b_valid_reg && advance && b_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_out_row      = m_row_reg;
    assign m_out_col      = m_col_reg;
    assign m_map_done     = m_done_reg;
    assign m_size_error   = m_err_reg;

    `MP2D_ASSERT(a_err_result_clean,
        m_valid && m_size_error |-> m_pooled_value == '0 && !m_map_done &&
            m_out_row == '0 && m_out_col == '0,
        "error result carries data")
    `MP2D_NEVER(a_no_write_on_err, ram_we && b_flags_reg.err,
        "column buffer written by error transaction")
    `MP2D_ASSERT(a_exec_holds,
        b_valid_reg && !advance |=> b_valid_reg && $stable(b_col_reg) && $stable(b_pixel_reg),
        "stalled execute stage changed")

endmodule
